// ----- rtl/sdp_pkg.sv -----
package sdp_pkg;

  localparam int unsigned MAX_SEQ_LEN = 65536;
  localparam int unsigned ADDR_W      = $clog2(MAX_SEQ_LEN);
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned MAX_BLOCK   = 64;
  localparam int unsigned BLK_W       = 7;
  localparam int unsigned HP_W        = $clog2(MAX_BLOCK * MAX_BLOCK) + 1;
  localparam int unsigned PX_W        = 26;
  localparam int unsigned CNT_W       = 33;
  localparam int unsigned SUM_W       = 49;
  localparam int unsigned SUM2_W      = 64;
  localparam int unsigned DIV_N_W     = 64;
  localparam int unsigned DIV_D_W     = 34;
  localparam int unsigned Q_W         = 16;
  localparam int unsigned Q_ONE       = 32768;
  localparam int unsigned Q_HALF      = 16384;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_STATS  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_STALE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_BPP  = 2'd0,
    CFG_MAXD = 2'd1,
    CFG_COMP = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RESP,
    S_ST_ROW,
    S_ST_COL,
    S_ST_ACC1,
    S_ST_ACC2,
    S_ST_TAIL,
    S_ST_FIN,
    S_MEAN_W,
    S_E2_GO,
    S_E2_W,
    S_VAR,
    S_SQRT,
    S_PX_SETUP,
    S_PX_ISTART,
    S_PX_ICHK,
    S_PX_IUSE,
    S_PX_JCHK,
    S_PX_JUSE,
    S_PX_DIV,
    S_PX_DWAIT,
    S_NORM,
    S_NORM_W
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_N_W-1:0]   quot;
  } div_rsp_t;

endpackage

// ----- rtl/sdp_if.sv -----
interface sdp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  base;
  logic [15:0] pix_x;
  logic [15:0] pix_y;

  modport source (output valid, output op, output base, output pix_x, output pix_y,
                  input ready);
  modport sink (input valid, input op, input base, input pix_x, input pix_y,
                output ready);
endinterface

interface sdp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] norm_intensity;
  logic [15:0] raw_intensity;
  logic [1:0]  status;

  modport source (output valid, output norm_intensity, output raw_intensity,
                  output status, input ready);
  modport sink (input valid, input norm_intensity, input raw_intensity,
                input status, output ready);
endinterface

// ----- rtl/self_dotplot_pixel_intensity_core.sv -----
// Self dot-plot pixel intensity engine.
// in_ch (valid/ready) carries one request: op, base, pix_x, pix_y. Every request
// gives exactly one result on out_ch: norm_intensity, raw_intensity, status.
// cfg_we/cfg_idx/cfg_data write the pixel size in bases (0), max_distance (1) and
// complement_mode (2); any of these drops the statistics. Write only when idle.
// Requests are handled one at a time by a sequencer around one shared
// radix-2 divider and the base store, which has one write and one read port.
// Clear and append go straight to the response. A query reads the store once per
//   base i and once per pair of the pixel, then runs at most one divide for the
//   pixel and one divide for the normalization.
// Statistics: every pixel is walked as a query is, rows beyond the sequence are
//   counted without a walk, then mean, second moment and square root follow.
// in_ch.ready is high only while the sequencer is idle. A finished result sits
// in an output register; a new request is taken while it waits, and the next
// result is held back until out_ch.ready takes the pending one.
// Reset (rst_n low, synchronous) empties the sequence, drops the statistics and
// restores the register defaults; the base store needs no clearing pass.
module self_dotplot_pixel_intensity_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  sdp_in_if.sink      in_ch,
  sdp_out_if.source   out_ch
);

  localparam int unsigned AW = sdp_pkg::ADDR_W;
  localparam int unsigned LW = sdp_pkg::LEN_W;
  localparam int unsigned PW = sdp_pkg::PX_W;
  localparam int unsigned QW = sdp_pkg::Q_W;

  sdp_pkg::state_t state_r, state_nxt;

  // configuration
  logic [sdp_pkg::BLK_W-1:0] bpp_r;
  logic [15:0]               maxd_r;
  logic                      comp_r;
  logic                      cfg_hit;
  logic [sdp_pkg::BLK_W-1:0] b_c;

  // persistent state
  logic [LW-1:0] len_r;
  logic          stats_valid_r;
  logic [QW-1:0] mean_r;
  logic [QW-1:0] dev_r;

  // base store
  logic [1:0]    mem [sdp_pkg::MAX_SEQ_LEN];
  logic [1:0]    q_r;
  logic          mem_we;
  logic [AW-1:0] rd_addr;

  // statistics walk
  logic [16:0]                 x_r;
  logic [17:0]                 xb_r;
  logic [15:0]                 y_r;
  logic [16:0]                 yb_r;
  logic [16:0]                 xmax_r;
  logic [sdp_pkg::CNT_W-1:0]   cnt_r;
  logic [sdp_pkg::SUM_W-1:0]   sum_r;
  logic [sdp_pkg::SUM2_W-1:0]  sum2_r;
  logic [31:0]                 sq_r;
  logic [16:0]                 m_r;
  logic [31:0]                 mm_r;
  logic [31:0]                 e2_r;
  logic [31:0]                 sv_r;
  logic [31:0]                 sr_r;
  logic [31:0]                 bit_r;
  logic [31:0]                 rb_c;
  logic [31:0]                 raw32_c;
  logic [31:0]                 m32_c;

  // pixel walk
  logic [15:0]            px_r;
  logic [15:0]            py_r;
  logic                   is_q_r;
  logic signed [PW-1:0]   i0_r, iend_r, i_r, j0_r, jend_r, j_r;
  logic signed [PW-1:0]   xs_c, bs_c, py_s, len_s, ij_c;
  logic                   igo_c, jgo_c;
  logic [1:0]             want_r;
  logic [sdp_pkg::HP_W-1:0] hits_r, pairs_r;
  logic [QW-1:0]          raw_r;
  logic [QW-1:0]          mag_c;
  logic                   neg_r;
  logic [31:0]            nq_c;
  logic [QW-1:0]          nres_c;

  // results
  logic [QW-1:0]          res_norm_r, res_raw_r;
  sdp_pkg::status_t       res_stat_r;
  logic                   out_valid_r;
  logic [QW-1:0]          out_norm_r, out_raw_r;
  logic [1:0]             out_stat_r;

  sdp_pkg::div_req_t div_req;
  sdp_pkg::div_rsp_t div_rsp;

  sdp_pkg::op_t op_c;
  logic         in_acc;
  logic         resp_go;

  sdp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign op_c    = sdp_pkg::op_t'(in_ch.op);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign resp_go = !out_valid_r || out_ch.ready;

  assign cfg_hit = cfg_we && (cfg_idx inside {sdp_pkg::CFG_BPP, sdp_pkg::CFG_MAXD,
                                              sdp_pkg::CFG_COMP});

  always_comb begin
    if (bpp_r == '0) begin
      b_c = sdp_pkg::BLK_W'(1);
    end else if (bpp_r > sdp_pkg::BLK_W'(sdp_pkg::MAX_BLOCK)) begin
      b_c = sdp_pkg::BLK_W'(sdp_pkg::MAX_BLOCK);
    end else begin
      b_c = bpp_r;
    end
  end

  assign bs_c  = $signed(PW'(b_c));
  assign py_s  = $signed(PW'(py_r));
  assign len_s = $signed(PW'(len_r));
  // column shifted back by half the row for the rotated track
  assign xs_c  = $signed(PW'(px_r)) - $signed(PW'(py_r[15:1]));
  assign ij_c  = i_r + j_r;
  assign igo_c = (i_r < iend_r) && (i_r < len_s);
  assign jgo_c = (j_r < jend_r) && (ij_c < len_s);

  assign mag_c   = (raw_r >= mean_r) ? raw_r - mean_r : mean_r - raw_r;
  assign rb_c    = sr_r + bit_r;
  assign raw32_c = 32'(raw_r);
  assign m32_c   = 32'(m_r);
  assign nq_c    = div_rsp.quot[31:0];

  always_comb begin
    if (neg_r) begin
      nres_c = (nq_c >= 32'(sdp_pkg::Q_HALF)) ? '0 : QW'(32'(sdp_pkg::Q_HALF) - nq_c);
    end else begin
      nres_c = (nq_c > 32'(sdp_pkg::Q_HALF)) ? QW'(sdp_pkg::Q_ONE)
                                             : QW'(32'(sdp_pkg::Q_HALF) + nq_c);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdp_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op_c)
            sdp_pkg::OP_STATS: state_nxt = sdp_pkg::S_ST_ROW;
            sdp_pkg::OP_QUERY: state_nxt = stats_valid_r ? sdp_pkg::S_PX_SETUP
                                                         : sdp_pkg::S_RESP;
            default:           state_nxt = sdp_pkg::S_RESP;
          endcase
        end
      end
      sdp_pkg::S_RESP: begin
        if (resp_go) state_nxt = sdp_pkg::S_IDLE;
      end
      sdp_pkg::S_ST_ROW: begin
        if (yb_r >= {1'b0, maxd_r}) begin
          state_nxt = sdp_pkg::S_ST_FIN;
        end else if (yb_r >= len_r) begin
          state_nxt = sdp_pkg::S_ST_TAIL;
        end else begin
          state_nxt = sdp_pkg::S_ST_COL;
        end
      end
      sdp_pkg::S_ST_COL: begin
        state_nxt = (xb_r >= {1'b0, len_r}) ? sdp_pkg::S_ST_ROW : sdp_pkg::S_PX_SETUP;
      end
      sdp_pkg::S_ST_ACC1: state_nxt = sdp_pkg::S_ST_ACC2;
      sdp_pkg::S_ST_ACC2: state_nxt = sdp_pkg::S_ST_COL;
      sdp_pkg::S_ST_TAIL: begin
        if (yb_r >= {1'b0, maxd_r}) state_nxt = sdp_pkg::S_ST_FIN;
      end
      sdp_pkg::S_ST_FIN: begin
        state_nxt = (cnt_r == '0) ? sdp_pkg::S_RESP : sdp_pkg::S_MEAN_W;
      end
      sdp_pkg::S_MEAN_W: begin
        if (div_rsp.done) state_nxt = sdp_pkg::S_E2_GO;
      end
      sdp_pkg::S_E2_GO: state_nxt = sdp_pkg::S_E2_W;
      sdp_pkg::S_E2_W: begin
        if (div_rsp.done) state_nxt = sdp_pkg::S_VAR;
      end
      sdp_pkg::S_VAR: state_nxt = sdp_pkg::S_SQRT;
      sdp_pkg::S_SQRT: begin
        if (bit_r == '0) state_nxt = sdp_pkg::S_RESP;
      end
      sdp_pkg::S_PX_SETUP:  state_nxt = sdp_pkg::S_PX_ISTART;
      sdp_pkg::S_PX_ISTART: state_nxt = sdp_pkg::S_PX_ICHK;
      sdp_pkg::S_PX_ICHK: begin
        state_nxt = igo_c ? sdp_pkg::S_PX_IUSE : sdp_pkg::S_PX_DIV;
      end
      sdp_pkg::S_PX_IUSE: state_nxt = sdp_pkg::S_PX_JCHK;
      sdp_pkg::S_PX_JCHK: begin
        state_nxt = jgo_c ? sdp_pkg::S_PX_JUSE : sdp_pkg::S_PX_ICHK;
      end
      sdp_pkg::S_PX_JUSE: state_nxt = sdp_pkg::S_PX_JCHK;
      sdp_pkg::S_PX_DIV: begin
        if (pairs_r != '0) begin
          state_nxt = sdp_pkg::S_PX_DWAIT;
        end else begin
          state_nxt = is_q_r ? sdp_pkg::S_NORM : sdp_pkg::S_ST_ACC1;
        end
      end
      sdp_pkg::S_PX_DWAIT: begin
        if (div_rsp.done) state_nxt = is_q_r ? sdp_pkg::S_NORM : sdp_pkg::S_ST_ACC1;
      end
      sdp_pkg::S_NORM: begin
        state_nxt = (dev_r == '0) ? sdp_pkg::S_RESP : sdp_pkg::S_NORM_W;
      end
      sdp_pkg::S_NORM_W: begin
        if (div_rsp.done) state_nxt = sdp_pkg::S_RESP;
      end
      default: state_nxt = sdp_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready      = (state_r == sdp_pkg::S_IDLE);
    rd_addr          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      sdp_pkg::S_PX_ICHK: rd_addr = i_r[AW-1:0];
      sdp_pkg::S_PX_JCHK: rd_addr = ij_c[AW-1:0];
      sdp_pkg::S_ST_FIN: begin
        // rounded mean: (2*sum + cnt) / (2*cnt)
        div_req.start    = (cnt_r != '0);
        div_req.dividend = sdp_pkg::DIV_N_W'({sum_r, 1'b0}) + sdp_pkg::DIV_N_W'(cnt_r);
        div_req.divisor  = sdp_pkg::DIV_D_W'({cnt_r, 1'b0});
      end
      sdp_pkg::S_E2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum2_r;
        div_req.divisor  = sdp_pkg::DIV_D_W'(cnt_r);
      end
      sdp_pkg::S_PX_DIV: begin
        div_req.start    = (pairs_r != '0);
        div_req.dividend = sdp_pkg::DIV_N_W'({hits_r, 16'b0}) + sdp_pkg::DIV_N_W'(pairs_r);
        div_req.divisor  = sdp_pkg::DIV_D_W'({pairs_r, 1'b0});
      end
      sdp_pkg::S_NORM: begin
        // |raw-mean|*16384 / sd rounded half up: (2*mag*16384 + sd) / (2*sd)
        div_req.start    = (dev_r != '0);
        div_req.dividend = sdp_pkg::DIV_N_W'({mag_c, 15'b0}) + sdp_pkg::DIV_N_W'(dev_r);
        div_req.divisor  = sdp_pkg::DIV_D_W'({dev_r, 1'b0});
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // base store
  assign mem_we = in_acc && (op_c == sdp_pkg::OP_APPEND) && !len_r[AW];

  always_ff @(posedge clk) begin
    if (mem_we) mem[len_r[AW-1:0]] <= in_ch.base;
    q_r <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r  <= sdp_pkg::BLK_W'(1);
      maxd_r <= 16'd100;
      comp_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sdp_pkg::CFG_BPP:  bpp_r  <= cfg_data[sdp_pkg::BLK_W-1:0];
        sdp_pkg::CFG_MAXD: maxd_r <= cfg_data;
        sdp_pkg::CFG_COMP: comp_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sdp_pkg::S_IDLE;
      len_r         <= '0;
      stats_valid_r <= 1'b0;
      mean_r        <= '0;
      dev_r         <= QW'(sdp_pkg::Q_ONE);
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ((state_r == sdp_pkg::S_RESP) && resp_go) ||
                     (out_valid_r && !out_ch.ready);
      if (cfg_hit || mem_we || (in_acc && op_c == sdp_pkg::OP_CLEAR)) begin
        stats_valid_r <= 1'b0;
      end
      case (state_r)
        sdp_pkg::S_IDLE: begin
          if (in_acc && op_c == sdp_pkg::OP_CLEAR) begin
            len_r <= '0;
          end
          if (mem_we) begin
            len_r <= len_r + 1'b1;
          end
        end
        sdp_pkg::S_ST_FIN: begin
          if (cnt_r == '0) begin
            mean_r        <= '0;
            dev_r         <= QW'(sdp_pkg::Q_ONE);
            stats_valid_r <= 1'b1;
          end
        end
        sdp_pkg::S_SQRT: begin
          if (bit_r == '0) begin
            mean_r        <= m_r[QW-1:0];
            dev_r         <= sr_r[QW-1:0];
            stats_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      sdp_pkg::S_IDLE: begin
        if (in_acc) begin
          res_norm_r <= '0;
          res_raw_r  <= '0;
          res_stat_r <= sdp_pkg::STAT_OK;
          y_r        <= '0;
          yb_r       <= '0;
          xmax_r     <= '0;
          cnt_r      <= '0;
          sum_r      <= '0;
          sum2_r     <= '0;
          px_r       <= in_ch.pix_x;
          py_r       <= in_ch.pix_y;
          is_q_r     <= (op_c == sdp_pkg::OP_QUERY);
          if (op_c == sdp_pkg::OP_APPEND && len_r[AW]) res_stat_r <= sdp_pkg::STAT_FULL;
          if (op_c == sdp_pkg::OP_QUERY && !stats_valid_r) begin
            res_stat_r <= sdp_pkg::STAT_STALE;
          end
        end
      end
      sdp_pkg::S_ST_ROW: begin
        x_r  <= '0;
        xb_r <= '0;
      end
      sdp_pkg::S_ST_COL: begin
        if (xb_r >= {1'b0, len_r}) begin
          xmax_r <= x_r;
          y_r    <= y_r + 1'b1;
          yb_r   <= yb_r + 17'(b_c);
        end else begin
          px_r <= x_r[15:0];
          py_r <= y_r;
        end
      end
      sdp_pkg::S_ST_ACC1: begin
        sq_r  <= raw32_c * raw32_c;
        sum_r <= sum_r + sdp_pkg::SUM_W'(raw_r);
        cnt_r <= cnt_r + 1'b1;
      end
      sdp_pkg::S_ST_ACC2: begin
        sum2_r <= sum2_r + sdp_pkg::SUM2_W'(sq_r);
        x_r    <= x_r + 1'b1;
        xb_r   <= xb_r + 18'(b_c);
      end
      sdp_pkg::S_ST_TAIL: begin
        // rows past the sequence hold pixels with no pairs
        if (yb_r < {1'b0, maxd_r}) begin
          cnt_r <= cnt_r + sdp_pkg::CNT_W'(xmax_r);
          yb_r  <= yb_r + 17'(b_c);
        end
      end
      sdp_pkg::S_MEAN_W: begin
        if (div_rsp.done) m_r <= div_rsp.quot[16:0];
      end
      sdp_pkg::S_E2_GO: begin
        mm_r <= m32_c * m32_c;
      end
      sdp_pkg::S_E2_W: begin
        if (div_rsp.done) e2_r <= div_rsp.quot[31:0];
      end
      sdp_pkg::S_VAR: begin
        sv_r  <= (e2_r > mm_r) ? e2_r - mm_r : '0;
        sr_r  <= '0;
        bit_r <= 32'h4000_0000;
      end
      sdp_pkg::S_SQRT: begin
        if (bit_r != '0) begin
          if (sv_r >= rb_c) begin
            sv_r <= sv_r - rb_c;
            sr_r <= (sr_r >> 1) + bit_r;
          end else begin
            sr_r <= sr_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      sdp_pkg::S_PX_SETUP: begin
        i0_r    <= xs_c * bs_c;
        j0_r    <= py_s * bs_c;
        hits_r  <= '0;
        pairs_r <= '0;
      end
      sdp_pkg::S_PX_ISTART: begin
        iend_r <= i0_r + bs_c;
        i_r    <= (i0_r < 0) ? '0 : i0_r;
        jend_r <= j0_r + bs_c;
      end
      sdp_pkg::S_PX_IUSE: begin
        // complement of a 2-bit base is 3 - x
        want_r <= comp_r ? ~q_r : q_r;
        j_r    <= j0_r;
      end
      sdp_pkg::S_PX_JCHK: begin
        if (!jgo_c) i_r <= i_r + $signed(PW'(1));
      end
      sdp_pkg::S_PX_JUSE: begin
        if (q_r == want_r) hits_r <= hits_r + 1'b1;
        pairs_r <= pairs_r + 1'b1;
        j_r     <= j_r + $signed(PW'(1));
      end
      sdp_pkg::S_PX_DIV: begin
        if (pairs_r == '0) raw_r <= '0;
      end
      sdp_pkg::S_PX_DWAIT: begin
        if (div_rsp.done) raw_r <= div_rsp.quot[QW-1:0];
      end
      sdp_pkg::S_NORM: begin
        neg_r      <= raw_r < mean_r;
        res_raw_r  <= raw_r;
        res_norm_r <= QW'(sdp_pkg::Q_HALF);
      end
      sdp_pkg::S_NORM_W: begin
        if (div_rsp.done) res_norm_r <= nres_c;
      end
      sdp_pkg::S_RESP: begin
        if (resp_go) begin
          out_norm_r <= res_norm_r;
          out_raw_r  <= res_raw_r;
          out_stat_r <= res_stat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.norm_intensity = out_norm_r;
  assign out_ch.raw_intensity  = out_raw_r;
  assign out_ch.status         = out_stat_r;

  a_stats_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stats_valid_r) |-> ($past(state_r) == sdp_pkg::S_SQRT ||
                              $past(state_r) == sdp_pkg::S_ST_FIN))
    else $error("statistics marked valid outside the statistics pass");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(sdp_pkg::MAX_SEQ_LEN))
    else $error("sequence length beyond store depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> len_r != '0)
    else $error("append did not advance the length");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_dev_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dev_r <= QW'(sdp_pkg::Q_ONE))
    else $error("deviation above one");

endmodule

// ----- rtl/sdp_div.sv -----
module sdp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sdp_pkg::div_req_t req,
  output sdp_pkg::div_rsp_t rsp
);

  localparam int unsigned STEP_W = $clog2(sdp_pkg::DIV_N_W);

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_W-1:0]             step_r;
  logic [sdp_pkg::DIV_N_W-1:0]   quo_r;
  logic [sdp_pkg::DIV_D_W-1:0]   rem_r;
  logic [sdp_pkg::DIV_D_W-1:0]   den_r;
  logic [sdp_pkg::DIV_D_W:0]     trial_c;
  logic [sdp_pkg::DIV_D_W:0]     diff_c;
  logic                          ge_c;

  // restoring divide, one quotient bit per cycle, dividend shifts out of quo_r
  assign trial_c = {rem_r, quo_r[sdp_pkg::DIV_N_W-1]};
  assign ge_c    = trial_c >= {1'b0, den_r};
  assign diff_c  = trial_c - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(sdp_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[sdp_pkg::DIV_N_W-2:0], ge_c};
      rem_r <= ge_c ? diff_c[sdp_pkg::DIV_D_W-1:0] : trial_c[sdp_pkg::DIV_D_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule
